FILE: design/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants of the ascending bubble-sort block.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int DATA_W = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] element_value;
    logic                     is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;
  } out_item_t;

endpackage

FILE: design/bsa_mem.sv
// ----------------------------------------------------------------------------
// bsa_mem
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsa_mem #(
  parameter int DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [bsa_pkg::DATA_W-1:0]   wdata,
  input  logic                         re,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [bsa_pkg::DATA_W-1:0]   rdata
);
  import bsa_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/bubble_sort_ascending_core.sv
// ----------------------------------------------------------------------------
// bubble_sort_ascending_core
// Collects a set of signed values, bubble-sorts it in memory, emits it.
// ----------------------------------------------------------------------------
// Input requests carry one element each and are taken one per cycle while
// the block is loading. The request with is_last set closes the set; in_stall
// then stays high until the last sorted result has been handed to the output
// register. Elements beyond MAX_ELEMENTS are dropped and overflow is set on
// every result of that set.
// The sort walks the store with one read and one write per cycle, carrying
// the running maximum in a register; each pass (ST_PSTART, ST_SCAN, ST_PEND)
// ends by writing that maximum at the pass limit, which then drops by one.
// Results leave one at a time, ascending, with last_out on the final one; each
// is read in ST_EFETCH and taken from registered read data in ST_EWAIT. A stall
// on the output holds the output register and pauses emission; loading of the
// next set starts as soon as the final result sits in the output register.
// Reset (rst_n low, synchronous) empties the set and clears the output valid.
// Store contents need no reset; only entries written for the open set are read.
// ----------------------------------------------------------------------------
module bubble_sort_ascending_core #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bsa_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output bsa_pkg::out_item_t  out_item
);
  import bsa_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_PSTART = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_PEND   = 3'd3;
  localparam logic [2:0] ST_EFETCH = 3'd4;
  localparam logic [2:0] ST_EWAIT  = 3'd5;

  logic [2:0]               state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic                     dropped_r, dropped_nxt;
  logic [AW-1:0]            limit_r, limit_nxt;
  logic [AW-1:0]            k_r, k_nxt;
  logic [AW-1:0]            e_r, e_nxt;
  logic signed [DATA_W-1:0] carry_r, carry_nxt;
  out_item_t                out_r, out_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic signed [DATA_W-1:0] mem_wdata, mem_rdata;

  logic          in_acc, full, out_free;
  logic [CW-1:0] cnt_inc, cnt_after, cnt_after_m1, cnt_m1;
  logic [AW-1:0] last_idx;

  bsa_mem #(
    .DEPTH (MAX_ELEMENTS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_stall     = (state_r != ST_LOAD);
  assign in_acc       = in_valid && !in_stall;
  assign full         = (count_r == MAX_CNT);
  assign cnt_inc      = count_r + 1'b1;
  assign cnt_after    = full ? count_r : cnt_inc;
  assign cnt_after_m1 = cnt_after - 1'b1;
  assign cnt_m1       = count_r - 1'b1;
  assign last_idx     = cnt_m1[AW-1:0];
  assign out_free     = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    limit_nxt     = limit_r;
    k_nxt         = k_r;
    e_nxt         = e_r;
    carry_nxt     = carry_r;
    out_nxt       = out_r;
    out_valid_nxt = (out_valid_r && out_stall);
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = carry_r;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (!full) begin
            mem_we    = 1'b1;
            mem_waddr = count_r[AW-1:0];
            mem_wdata = in_item.element_value;
          end else begin
            dropped_nxt = 1'b1;
          end
          count_nxt = cnt_after;
          if (in_item.is_last) begin
            e_nxt = '0;
            if (cnt_after >= CW'(2)) begin
              limit_nxt = cnt_after_m1[AW-1:0];
              state_nxt = ST_PSTART;
            end else begin
              state_nxt = ST_EFETCH;
            end
          end
        end
      end
      ST_PSTART: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        k_nxt     = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (k_r == '0) begin
          carry_nxt = mem_rdata;
        end else if (carry_r > mem_rdata) begin
          mem_we    = 1'b1;
          mem_waddr = k_r - 1'b1;
          mem_wdata = mem_rdata;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = k_r - 1'b1;
          mem_wdata = carry_r;
          carry_nxt = mem_rdata;
        end
        if (k_r == limit_r) begin
          state_nxt = ST_PEND;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = k_r + 1'b1;
          k_nxt     = k_r + 1'b1;
        end
      end
      ST_PEND: begin
        mem_we    = 1'b1;
        mem_waddr = limit_r;
        mem_wdata = carry_r;
        limit_nxt = limit_r - 1'b1;
        if (limit_r == AW'(1)) begin
          state_nxt = ST_EFETCH;
        end else begin
          state_nxt = ST_PSTART;
        end
      end
      ST_EFETCH: begin
        mem_re    = 1'b1;
        mem_raddr = e_r;
        state_nxt = ST_EWAIT;
      end
      ST_EWAIT: begin
        if (out_free) begin
          out_nxt.sorted_value = mem_rdata;
          out_nxt.last_out     = (e_r == last_idx);
          out_nxt.overflow     = dropped_r;
          out_valid_nxt        = 1'b1;
          if (e_r == last_idx) begin
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            state_nxt   = ST_LOAD;
          end else begin
            e_nxt     = e_r + 1'b1;
            state_nxt = ST_EFETCH;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    limit_r <= limit_nxt;
    k_r     <= k_nxt;
    e_r     <= e_nxt;
    carry_r <= carry_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
